// ===== design/cpst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpst_pkg
// shared types and constants for the call-site profiling statistics table
// ----------------------------------------------------------------------------
package cpst_pkg;

    localparam int STACK_DEPTH_DEF   = 64;
    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int IN_W  = 128;
    localparam int OUT_W = 352;

    typedef enum logic [1:0] {
        KIND_ENTRY = 2'd0,
        KIND_EXIT  = 2'd1,
        KIND_FLUSH = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_STACK_FULL  = 3'd1,
        ST_STACK_EMPTY = 3'd2,
        ST_TABLE_FULL  = 3'd3,
        ST_DISABLED    = 3'd4,
        ST_RECORD      = 3'd5
    } status_t;

    // classified command handed from front to back
    typedef struct packed {
        kind_t       kind;
        logic [31:0] caller;
        logic [31:0] callee;
        logic [63:0] ts;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] duration;
        logic [31:0] site_caller;
        logic [31:0] site_callee;
        logic [31:0] call_count;
        logic [63:0] sum_cycles;
        logic [63:0] min_cycles;
        logic [63:0] max_cycles;
        logic        last;
    } result_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_POP,
        BK_SEARCH,
        BK_UPDATE,
        BK_FLUSH,
        BK_EMIT
    } bk_state_t;

endpackage
`default_nettype wire

// ===== design/cpst_cmd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpst_cmd_fifo
// short command queue between the event front end and the table engine
// ----------------------------------------------------------------------------
module cpst_cmd_fifo
    import cpst_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_data,
    output logic      full,
    input  wire logic pop,
    output cmd_t      pop_data,
    output logic      empty
);
    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
                wp_reg <= ~wp_reg;
            if (pop && !empty)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, (push && !full)} - {1'b0, (pop && !empty)};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !(pop && !empty)) |=> !empty)
        else $error("push lost");
endmodule
`default_nettype wire

// ===== design/cpst_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cpst_back
// shadow stack and statistics table engine: push, pop, search, update and flush
// ----------------------------------------------------------------------------
module cpst_back
    import cpst_pkg::*;
#(
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic enable,
    input  cmd_t      cmd,
    input  wire logic cmd_valid,
    output logic      cmd_pop,
    output result_t   res,
    output logic      res_valid,
    input  wire logic res_ready
);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int TW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    // shadow stack memory
    logic [127:0] stk_mem [STACK_DEPTH];
    logic [127:0] stk_rd_reg;
    logic [DW-1:0] depth_reg, depth_next;

    // table: keys and valid bits in flops for parallel compare, stats in memory
    logic [63:0]  key_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [223:0] stat_mem [TABLE_ENTRIES];
    logic [223:0] stat_rd_reg;

    bk_state_t state_reg, state_next;
    cmd_t      cur_reg, cur_next;
    logic [63:0] dur_reg, dur_next;
    logic [TW-1:0] slot_reg, slot_next;
    logic        hit_reg, hit_next;
    logic        full_reg, full_next;
    logic [CW-1:0] left_reg, left_next;
    result_t   out_reg, out_next;
    logic      ov_reg, ov_next;

    // stack, stats and key port controls
    logic          stk_we;
    logic [SW-1:0] stk_addr;
    logic [127:0]  stk_wdata;
    logic          stat_we;
    logic [223:0]  stat_wdata;
    logic [TW-1:0] stat_raddr;
    logic          key_we;

    // match and free search
    logic [TABLE_ENTRIES-1:0] match_vec;
    logic [TW-1:0] hit_idx, free_idx, first_valid;
    logic any_hit, any_free;
    logic [63:0] cur_key;

    function automatic logic [TW-1:0] first_valid_after(
        input logic [TABLE_ENTRIES-1:0] v, input logic [TW-1:0] cur);
        logic [TW-1:0] r;
        logic found;
        r = '0;
        found = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (!found && v[i] && (TW'(i) > cur))
            begin
                r = TW'(i);
                found = 1'b1;
            end
        end
        return r;
    endfunction

    assign cur_key = {stk_rd_reg[127:96], stk_rd_reg[95:64]};

    // pushes only happen from idle, straight from the queue head
    assign stk_wdata = {cmd.caller, cmd.callee, cmd.ts};

    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
            match_vec[i] = valid_reg[i] && (key_reg[i] == cur_key);
    end

    always_comb
    begin
        hit_idx     = '0;
        free_idx    = '0;
        first_valid = '0;
        any_hit     = 1'b0;
        any_free    = 1'b0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit_idx = TW'(i);
                any_hit = 1'b1;
            end
            if (!valid_reg[i])
            begin
                free_idx = TW'(i);
                any_free = 1'b1;
            end
            if (valid_reg[i])
                first_valid = TW'(i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_addr] <= stk_wdata;
        stk_rd_reg <= stk_mem[stk_addr];
        if (stat_we)
            stat_mem[slot_reg] <= stat_wdata;
        stat_rd_reg <= stat_mem[stat_raddr];
        if (key_we)
            key_reg[slot_reg] <= cur_key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            depth_reg <= '0;
            valid_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            valid_reg <= valid_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        dur_reg  <= dur_next;
        slot_reg <= slot_next;
        hit_reg  <= hit_next;
        full_reg <= full_next;
        left_reg <= left_next;
        out_reg  <= out_next;
    end

    assign res       = out_reg;
    assign res_valid = ov_reg;

    logic [31:0] s_cnt;
    logic [63:0] s_sum, s_min, s_max;
    assign {s_cnt, s_sum, s_min, s_max} = stat_rd_reg;

    always_comb
    begin
        state_next = state_reg;
        depth_next = depth_reg;
        valid_next = valid_reg;
        cur_next   = cur_reg;
        dur_next   = dur_reg;
        slot_next  = slot_reg;
        hit_next   = hit_reg;
        full_next  = full_reg;
        left_next  = left_reg;
        out_next   = out_reg;
        ov_next    = ov_reg && !res_ready;
        cmd_pop    = 1'b0;
        stk_we     = 1'b0;
        stk_addr   = depth_reg[SW-1:0];
        stat_we    = 1'b0;
        stat_wdata = '0;
        stat_raddr = slot_reg;
        key_we     = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && !ov_next)
                begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd;
                    out_next = '0;
                    out_next.last = 1'b1;
                    unique case (cmd.kind)
                        KIND_ENTRY:
                        begin
                            ov_next = 1'b1;
                            if (!enable)
                                out_next.status = ST_DISABLED;
                            else if (depth_reg >= DW'(STACK_DEPTH))
                                out_next.status = ST_STACK_FULL;
                            else
                            begin
                                out_next.status = ST_OK;
                                stk_we   = 1'b1;
                                cur_next = cmd;
                                depth_next = depth_reg + 1'b1;
                            end
                        end
                        KIND_EXIT:
                        begin
                            if (depth_reg == '0)
                            begin
                                out_next.status = ST_STACK_EMPTY;
                                ov_next = 1'b1;
                            end
                            else
                            begin
                                depth_next = depth_reg - 1'b1;
                                stk_addr   = depth_next[SW-1:0];
                                state_next = BK_POP;
                            end
                        end
                        KIND_FLUSH:
                        begin
                            if (valid_reg == '0)
                            begin
                                out_next.status = ST_OK;
                                ov_next = 1'b1;
                            end
                            else
                            begin
                                left_next  = CW'($countones(valid_reg));
                                slot_next  = first_valid;
                                stat_raddr = first_valid;
                                state_next = BK_FLUSH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_POP:
            begin
                // stack data registered; search the table
                dur_next   = cur_reg.ts - stk_rd_reg[63:0];
                hit_next   = any_hit;
                full_next  = !any_hit && !any_free;
                slot_next  = any_hit ? hit_idx : free_idx;
                stat_raddr = slot_next;
                state_next = BK_SEARCH;
            end
            BK_SEARCH:
            begin
                state_next = BK_UPDATE;
            end
            BK_UPDATE:
            begin
                out_next = '0;
                out_next.last        = 1'b1;
                out_next.duration    = dur_reg;
                out_next.site_caller = stk_rd_reg[127:96];
                out_next.site_callee = stk_rd_reg[95:64];
                if (full_reg)
                    out_next.status = ST_TABLE_FULL;
                else
                begin
                    out_next.status = ST_OK;
                    if (hit_reg)
                    begin
                        out_next.call_count = s_cnt + 32'd1;
                        out_next.sum_cycles = s_sum + dur_reg;
                        out_next.min_cycles = (dur_reg < s_min) ? dur_reg : s_min;
                        out_next.max_cycles = (dur_reg > s_max) ? dur_reg : s_max;
                    end
                    else
                    begin
                        out_next.call_count = 32'd1;
                        out_next.sum_cycles = dur_reg;
                        out_next.min_cycles = dur_reg;
                        out_next.max_cycles = dur_reg;
                        key_we = 1'b1;
                        valid_next[slot_reg] = 1'b1;
                    end
                    stat_we    = 1'b1;
                    stat_wdata = {out_next.call_count, out_next.sum_cycles,
                                  out_next.min_cycles, out_next.max_cycles};
                end
                ov_next    = 1'b1;
                state_next = BK_IDLE;
            end
            BK_FLUSH:
            begin
                // stats of slot_reg arriving; wait for output room
                if (!ov_next)
                    state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                out_next = '0;
                out_next.status      = ST_RECORD;
                out_next.site_caller = key_reg[slot_reg][63:32];
                out_next.site_callee = key_reg[slot_reg][31:0];
                out_next.call_count  = s_cnt;
                out_next.sum_cycles  = s_sum;
                out_next.min_cycles  = s_min;
                out_next.max_cycles  = s_max;
                out_next.last        = (left_reg == CW'(1));
                ov_next              = 1'b1;
                valid_next[slot_reg] = 1'b0;
                left_next            = left_reg - 1'b1;
                if (left_reg == CW'(1))
                    state_next = BK_IDLE;
                else
                begin
                    slot_next  = first_valid_after(valid_reg, slot_reg);
                    stat_raddr = slot_next;
                    state_next = BK_FLUSH;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n) depth_reg <= DW'(STACK_DEPTH))
        else $error("stack depth overrun");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !res_ready) |=> (ov_reg && $stable(out_reg)))
        else $error("stalled result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == BK_IDLE))
        else $error("command taken while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_EMIT) |-> valid_reg[slot_reg])
        else $error("flush emitting invalid slot");
endmodule
`default_nettype wire

// ===== design/call_profile_stats_table_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// call_profile_stats_table_core
// call-site profiler: shadow stack plus per-site call statistics table
// ----------------------------------------------------------------------------
// results: tvalid is registered; entries, stack-full, stack-empty and disabled errors and an
// empty flush are answered from the queue head, an exit after stack read, table search, stats read, update
// flush: one record per valid slot, each after a stats read and an emit step
// throughput: 1 entry per cycle while the output is not stalled; exits are taken one at a time,
// limited by the back-end sequencer and its single-port stack memory; a two-deep queue decouples input
// reset: stack empty, table empty, enable set; memories are not cleared
module call_profile_stats_table_core
    import cpst_pkg::*;
#(
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_wdata,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [IN_W-1:0]   s_axis_tdata,   // caller, callee, timestamp
    input  wire logic [1:0]        s_axis_tuser,   // kind
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [OUT_W-1:0]       m_axis_tdata,   // duration, site_caller, site_callee,
                                                   // call_count, sum, min, max
    output logic [2:0]             m_axis_tuser,   // status
    output logic                   m_axis_tlast
);
    logic enable_reg;
    cmd_t in_cmd, q_cmd;
    logic q_full, q_empty, q_pop;
    result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enable_reg <= 1'b1;
        else if (cfg_we)
            enable_reg <= cfg_wdata;
    end

    // front: kind 3 carries no work and is discarded here
    assign in_cmd.kind   = kind_t'(s_axis_tuser);
    assign in_cmd.caller = s_axis_tdata[31:0];
    assign in_cmd.callee = s_axis_tdata[63:32];
    assign in_cmd.ts     = s_axis_tdata[127:64];
    assign s_axis_tready = !q_full;

    cpst_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_axis_tvalid && (in_cmd.kind != KIND_NONE)),
        .push_data (in_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_cmd),
        .empty     (q_empty)
    );

    cpst_back #(
        .STACK_DEPTH   (STACK_DEPTH),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (enable_reg),
        .cmd       (q_cmd),
        .cmd_valid (!q_empty),
        .cmd_pop   (q_pop),
        .res       (res),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready)
    );

    assign m_axis_tuser = res.status;
    assign m_axis_tlast = res.last;
    assign m_axis_tdata = {res.max_cycles, res.min_cycles, res.sum_cycles,
                           res.call_count, res.site_callee, res.site_caller,
                           res.duration};
endmodule
`default_nettype wire
